@@ hw/rtl/gfbr_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gfbr_pkg: shared types and constants
// Widths, CORDIC angle table, filter coefficients and the front-to-back queue
// entry used by the GMSK bit recovery blocks.
// ----------------------------------------------------------------------------
package gfbr_pkg;

  localparam int unsigned SampleWidthDef = 16;
  localparam int unsigned FilterTapsDef  = 36;
  localparam int unsigned AngleW         = 16;
  localparam int unsigned IncW           = 16;
  localparam logic [IncW-1:0] IncReset   = 16'd13107;
  localparam int unsigned CordicSteps    = 16;
  localparam int unsigned QueueDepth     = 2;

  // Entry handed from the front end to the back end.
  typedef struct packed {
    logic              restart;
    logic [AngleW-1:0] angle;
  } gfbr_item_t;

  typedef enum logic [1:0] {
    FE_IDLE,
    FE_MULT,
    FE_CORDIC,
    FE_PUSH
  } fe_state_t;

  typedef enum logic [1:0] {
    BE_IDLE,
    BE_MAC,
    BE_PLL,
    BE_OUT
  } be_state_t;

  function automatic logic [AngleW-1:0] cordic_atan(input logic [3:0] k);
    logic [AngleW-1:0] v;
    case (k)
      4'd0:    v = 16'd8192;
      4'd1:    v = 16'd4836;
      4'd2:    v = 16'd2555;
      4'd3:    v = 16'd1297;
      4'd4:    v = 16'd651;
      4'd5:    v = 16'd326;
      4'd6:    v = 16'd163;
      4'd7:    v = 16'd81;
      4'd8:    v = 16'd41;
      4'd9:    v = 16'd20;
      4'd10:   v = 16'd10;
      4'd11:   v = 16'd5;
      4'd12:   v = 16'd3;
      4'd13:   v = 16'd1;
      4'd14:   v = 16'd1;
      default: v = 16'd0;
    endcase
    return v;
  endfunction

  // Coefficient for distance m from the centre of the filter.
  function automatic logic [14:0] gauss_coef(input logic [2:0] m);
    logic [14:0] v;
    case (m)
      3'd0:    v = 15'd26713;
      3'd1:    v = 15'd11763;
      3'd2:    v = 15'd2281;
      3'd3:    v = 15'd195;
      3'd4:    v = 15'd7;
      default: v = 15'd0;
    endcase
    return v;
  endfunction

endpackage

@@ hw/rtl/gfbr_front.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gfbr_front: FM discriminator
// Takes samples, forms sample times conjugate of the previous one and runs a
// sixteen-step CORDIC to find the binary angle.
// ----------------------------------------------------------------------------
module gfbr_front import gfbr_pkg::*; #(
  parameter int unsigned SAMPLE_WIDTH = SampleWidthDef
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic signed [SAMPLE_WIDTH-1:0] in_i,
  input  logic signed [SAMPLE_WIDTH-1:0] in_q,
  input  logic                           in_restart,
  output logic                           q_valid,
  input  logic                           q_ready,
  output gfbr_item_t                     q_item
);

  localparam int unsigned PW = 2 * SAMPLE_WIDTH + 1;
  localparam int unsigned XW = PW + 2;

  fe_state_t state_r, state_nxt;
  logic signed [SAMPLE_WIDTH-1:0] prev_i_r, prev_q_r, cur_i_r, cur_q_r;
  logic signed [PW-1:0] pii_r, pqq_r, pqi_r, pip_r;
  logic signed [XW-1:0] x_r, y_r;
  logic [AngleW-1:0] ang_r;
  logic [3:0] k_r;
  logic mstep_r, zero_r, restart_r;
  logic signed [XW-1:0] re_w, im_w, dx_w, dy_w;

  assign re_w = XW'(pii_r) + XW'(pqq_r);
  assign im_w = XW'(pqi_r) - XW'(pip_r);
  assign dx_w = y_r >>> k_r;
  assign dy_w = x_r >>> k_r;

  always_comb begin
    state_nxt = state_r;
    in_ready  = 1'b0;
    q_valid   = 1'b0;
    case (state_r)
      FE_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) state_nxt = in_restart ? FE_PUSH : FE_MULT;
      end
      FE_MULT:   if (mstep_r) state_nxt = FE_CORDIC;
      FE_CORDIC: if (k_r == 4'd15) state_nxt = FE_PUSH;
      FE_PUSH: begin
        q_valid = 1'b1;
        if (q_ready) state_nxt = FE_IDLE;
      end
      default: state_nxt = FE_IDLE;
    endcase
  end

  assign q_item.restart = restart_r;
  assign q_item.angle   = zero_r ? '0 : ang_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= FE_IDLE;
      prev_i_r <= '0;
      prev_q_r <= '0;
      mstep_r  <= 1'b0;
      k_r      <= '0;
    end else begin
      state_r <= state_nxt;
      case (state_r)
        FE_IDLE: if (in_valid) begin
          restart_r <= in_restart;
          mstep_r   <= 1'b0;
          if (in_restart) begin
            prev_i_r <= '0;
            prev_q_r <= '0;
          end else begin
            cur_i_r  <= in_i;
            cur_q_r  <= in_q;
          end
        end
        FE_MULT: begin
          if (!mstep_r) begin
            pii_r    <= PW'(cur_i_r * prev_i_r);
            pqq_r    <= PW'(cur_q_r * prev_q_r);
            pqi_r    <= PW'(cur_q_r * prev_i_r);
            pip_r    <= PW'(cur_i_r * prev_q_r);
            prev_i_r <= cur_i_r;
            prev_q_r <= cur_q_r;
            mstep_r  <= 1'b1;
          end else begin
            k_r    <= '0;
            zero_r <= (re_w == '0) && (im_w == '0);
            if (re_w < 0) begin
              x_r   <= -re_w;
              y_r   <= -im_w;
              ang_r <= 16'h8000;
            end else begin
              x_r   <= re_w;
              y_r   <= im_w;
              ang_r <= '0;
            end
          end
        end
        FE_CORDIC: begin
          k_r <= k_r + 4'd1;
          if (y_r > 0) begin
            x_r   <= x_r + dx_w;
            y_r   <= y_r - dy_w;
            ang_r <= ang_r + cordic_atan(k_r);
          end else begin
            x_r   <= x_r - dx_w;
            y_r   <= y_r + dy_w;
            ang_r <= ang_r - cordic_atan(k_r);
          end
        end
        default: ;
      endcase
    end
  end

endmodule

@@ hw/rtl/gfbr_queue.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gfbr_queue: small item queue
// Two-entry FIFO between the discriminator and the filter back end.
// ----------------------------------------------------------------------------
module gfbr_queue import gfbr_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       wr_valid,
  output logic       wr_ready,
  input  gfbr_item_t wr_item,
  output logic       rd_valid,
  input  logic       rd_ready,
  output gfbr_item_t rd_item
);

  gfbr_item_t mem_r [QueueDepth];
  logic wp_r, rp_r;
  logic [1:0] cnt_r;
  logic wr_en, rd_en;

  assign wr_ready = (cnt_r != 2'd2);
  assign rd_valid = (cnt_r != 2'd0);
  assign rd_item  = mem_r[rp_r];
  assign wr_en    = wr_valid && wr_ready;
  assign rd_en    = rd_valid && rd_ready;

  always_ff @(posedge clk) begin
    if (wr_en) mem_r[wp_r] <= wr_item;
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= '0;
    end else begin
      if (wr_en) wp_r <= ~wp_r;
      if (rd_en) rp_r <= ~rp_r;
      cnt_r <= cnt_r + 2'(wr_en) - 2'(rd_en);
    end
  end

endmodule

@@ hw/rtl/gfbr_back.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gfbr_back: matched filter, DPLL and NRZI decoder
// Runs the Gaussian filter one tap per cycle, steers the DPLL phase and
// slices bits on phase wrap.
// ----------------------------------------------------------------------------
module gfbr_back import gfbr_pkg::*; #(
  parameter int unsigned FILTER_TAPS = FilterTapsDef
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic [IncW-1:0] inc,
  input  logic            q_valid,
  output logic            q_ready,
  input  gfbr_item_t      q_item,
  output logic            out_valid,
  input  logic            out_ready,
  output logic            out_bit
);

  localparam int unsigned IW   = $clog2(FILTER_TAPS);
  localparam int unsigned HALF = FILTER_TAPS / 2;
  localparam int unsigned AW   = 32 + $clog2(FILTER_TAPS) + 1;

  be_state_t state_r, state_nxt;
  logic [AngleW-1:0] line_r [FILTER_TAPS];
  logic [FILTER_TAPS-1:0] vld_r;
  logic [IW-1:0] wi_r, ri_r;
  logic [IW:0] k_r;
  logic [AngleW-1:0] rd_r;
  logic rdv_r;
  logic signed [AW-1:0] acc_r;
  logic [16:0] phase_r;
  logic psign_r, pslice_r, bit_r;
  logic signed [AngleW-1:0] tap_w;
  logic [IW:0] kt_w;
  logic [IW:0] m_w;
  logic signed [15:0] coef_w;
  logic signed [31:0] prod_w;
  logic sign_w;
  logic [16:0] ph1_w, ph2_w;

  // The delay line is read through a register, so the word in rd_r belongs
  // to the tap one behind the counter.
  always_comb begin
    kt_w = k_r - (IW+1)'(1);
    if (kt_w >= (IW+1)'(HALF)) m_w = kt_w - (IW+1)'(HALF);
    else m_w = (IW+1)'(HALF - 1) - kt_w;
    coef_w = (m_w < 5) ? signed'({1'b0, gauss_coef(m_w[2:0])}) : 16'sd0;
    tap_w  = rdv_r ? signed'(rd_r) : 16'sd0;
  end

  assign prod_w = tap_w * coef_w;

  assign sign_w = acc_r > 0;
  always_comb begin
    ph1_w = phase_r;
    if (sign_w != psign_r) begin
      if (phase_r < 17'h08000) ph1_w = phase_r + 17'(inc[IncW-1:4]);
      else ph1_w = phase_r - 17'(inc[IncW-1:4]);
    end
    ph2_w = ph1_w + 17'(inc);
  end

  always_comb begin
    state_nxt = state_r;
    q_ready   = 1'b0;
    out_valid = 1'b0;
    case (state_r)
      BE_IDLE: begin
        q_ready = 1'b1;
        if (q_valid && !q_item.restart) state_nxt = BE_MAC;
      end
      BE_MAC: if (k_r == (IW+1)'(FILTER_TAPS)) state_nxt = BE_PLL;
      BE_PLL: state_nxt = ph2_w[16] ? BE_OUT : BE_IDLE;
      BE_OUT: begin
        out_valid = 1'b1;
        if (out_ready) state_nxt = BE_IDLE;
      end
      default: state_nxt = BE_IDLE;
    endcase
  end

  assign out_bit = bit_r;

  always_ff @(posedge clk) begin
    if (state_r == BE_IDLE && q_valid && !q_item.restart) line_r[wi_r] <= q_item.angle;
    rd_r  <= line_r[ri_r];
    rdv_r <= vld_r[ri_r];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= BE_IDLE;
      vld_r    <= '0;
      wi_r     <= '0;
      phase_r  <= '0;
      psign_r  <= 1'b0;
      pslice_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      case (state_r)
        BE_IDLE: if (q_valid) begin
          if (q_item.restart) begin
            vld_r    <= '0;
            wi_r     <= '0;
            phase_r  <= '0;
            psign_r  <= 1'b0;
            pslice_r <= 1'b0;
          end else begin
            vld_r[wi_r] <= 1'b1;
            ri_r  <= wi_r;
            wi_r  <= (wi_r == IW'(FILTER_TAPS - 1)) ? '0 : wi_r + 1'b1;
            k_r   <= '0;
            acc_r <= '0;
          end
        end
        BE_MAC: begin
          if (k_r != '0) acc_r <= acc_r + AW'(prod_w);
          k_r   <= k_r + 1'b1;
          ri_r  <= (ri_r == '0) ? IW'(FILTER_TAPS - 1) : ri_r - 1'b1;
        end
        BE_PLL: begin
          psign_r <= sign_w;
          phase_r <= {1'b0, ph2_w[15:0]};
          if (ph2_w[16]) begin
            bit_r    <= (sign_w == pslice_r);
            pslice_r <= sign_w;
          end
        end
        default: ;
      endcase
    end
  end

endmodule

@@ hw/rtl/gmsk_fm_bit_recovery_unit.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gmsk_fm_bit_recovery_unit: GMSK bit recovery top level
// FM discriminator, Gaussian matched filter, DPLL clock recovery and NRZI
// decoding of a complex baseband sample stream.
// ----------------------------------------------------------------------------
// Channel  | Direction | Transfer fields
// s_axis   | in        | tdata: sample_i, sample_q; tuser: restart
// m_axis   | out       | tdata: data_bit
// cfg      | in        | wdata: pll_increment
//
// The front end finishes each sample before it takes the next: products,
// 16 CORDIC steps, then a hand-over. The back end handles one sample at a
// time in its one multiply-accumulate unit, plus a hand-out state when a
// bit is produced, which sets the sustained rate.
// A two-entry queue lets both halves stall apart.
// Reset is synchronous; a restart transfer clears state without a result.
// ----------------------------------------------------------------------------
module gmsk_fm_bit_recovery_unit import gfbr_pkg::*; #(
  parameter int unsigned FILTER_TAPS  = FilterTapsDef,
  parameter int unsigned SAMPLE_WIDTH = SampleWidthDef
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  s_axis_tvalid,
  output logic                                  s_axis_tready,
  // sample_i, sample_q
  input  logic [((2*SAMPLE_WIDTH+7)/8)*8-1:0]   s_axis_tdata,
  // restart
  input  logic                                  s_axis_tuser,
  output logic                                  m_axis_tvalid,
  input  logic                                  m_axis_tready,
  // data_bit, then zero padding
  output logic [7:0]                            m_axis_tdata,
  input  logic                                  cfg_we,
  input  logic [IncW-1:0]                       cfg_wdata
);

  logic [IncW-1:0] inc_r;
  logic fq_valid, fq_ready, bq_valid, bq_ready, out_bit;
  gfbr_item_t fq_item, bq_item;

  // The increment register survives a restart.
  always_ff @(posedge clk) begin
    if (!rst_n) inc_r <= IncReset;
    else if (cfg_we) inc_r <= cfg_wdata;
  end

  gfbr_front #(.SAMPLE_WIDTH(SAMPLE_WIDTH)) u_front (
    .clk, .rst_n,
    .in_valid   (s_axis_tvalid),
    .in_ready   (s_axis_tready),
    .in_i       (s_axis_tdata[SAMPLE_WIDTH-1:0]),
    .in_q       (s_axis_tdata[2*SAMPLE_WIDTH-1:SAMPLE_WIDTH]),
    .in_restart (s_axis_tuser),
    .q_valid    (fq_valid),
    .q_ready    (fq_ready),
    .q_item     (fq_item)
  );

  gfbr_queue u_queue (
    .clk, .rst_n,
    .wr_valid (fq_valid), .wr_ready (fq_ready), .wr_item (fq_item),
    .rd_valid (bq_valid), .rd_ready (bq_ready), .rd_item (bq_item)
  );

  gfbr_back #(.FILTER_TAPS(FILTER_TAPS)) u_back (
    .clk, .rst_n,
    .inc       (inc_r),
    .q_valid   (bq_valid),
    .q_ready   (bq_ready),
    .q_item    (bq_item),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_bit   (out_bit)
  );

  assign m_axis_tdata = {7'd0, out_bit};

endmodule

@@ hw/rtl/gfbr_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gfbr_checker: port checks for the bit recovery unit
// Watches the stream ports of the top level over time.
// ----------------------------------------------------------------------------
module gfbr_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       s_axis_tvalid,
  input logic       s_axis_tready,
  input logic       m_axis_tvalid,
  input logic       m_axis_tready,
  input logic [7:0] m_axis_tdata
);

  // A result waiting to be taken holds its value.
  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result changed while stalled");

  // Padding bits of the result stay zero.
  a_pad_zero: assert property (@(posedge clk) disable iff (!rst_n)
    m_axis_tvalid |-> m_axis_tdata[7:1] == 7'd0)
    else $error("result padding not zero");

  // After an accepted sample the front end is busy next cycle.
  a_in_busy: assert property (@(posedge clk) disable iff (!rst_n)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("sample taken in back-to-back cycles");

  // No result straight after reset.
  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> !m_axis_tvalid)
    else $error("result shown after reset");

endmodule

bind gmsk_fm_bit_recovery_unit gfbr_checker u_checker (
  .clk, .rst_n, .s_axis_tvalid, .s_axis_tready,
  .m_axis_tvalid, .m_axis_tready, .m_axis_tdata
);

@@ dv/tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: GMSK bit recovery testbench
// Drives complex baseband samples, restarts and DPLL increment writes into the
// bit recovery unit. A scoreboard tracks discriminator, filter and DPLL state
// to predict each recovered bit and checks the output stream in order.
// ----------------------------------------------------------------------------
module tb;
  import gfbr_pkg::*;

  localparam int unsigned Taps = FilterTapsDef;
  localparam int unsigned Sw   = SampleWidthDef;
  localparam int unsigned DrainCycles = 200;

  // Scoreboard: holds its own copy of the recovery state and the bits that
  // the unit still owes us.
  class bit_recovery_sb;
    logic [IncW-1:0]   increment;
    longint            last_i, last_q;
    logic [AngleW-1:0] angles[Taps];
    int unsigned       wr_idx;
    int unsigned       phase;
    bit                last_sign, last_slice;
    bit                bits_owed[$];
    int                errors;

    function void clear();
      last_i = 0;
      last_q = 0;
      foreach (angles[k]) angles[k] = '0;
      wr_idx = 0;
      phase = 0;
      last_sign = 0;
      last_slice = 0;
    endfunction

    function longint fshift(longint v, int n);
      return v >>> n;
    endfunction

    function logic [AngleW-1:0] cordic_weight(int k);
      int unsigned w[16] = '{8192, 4836, 2555, 1297, 651, 326, 163, 81,
                             41, 20, 10, 5, 3, 1, 1, 0};
      return AngleW'(w[k]);
    endfunction

    function logic [AngleW-1:0] disc(longint x, longint y);
      logic [AngleW-1:0] a;
      longint dx, dy;
      a = '0;
      if (x == 0 && y == 0) return '0;
      if (x < 0) begin
        x = -x;
        y = -y;
        a = 16'h8000;
      end
      for (int k = 0; k < CordicSteps; k++) begin
        dx = fshift(y, k);
        dy = fshift(x, k);
        if (y > 0) begin
          x += dx;
          y -= dy;
          a += cordic_weight(k);
        end else begin
          x -= dx;
          y += dy;
          a -= cordic_weight(k);
        end
      end
      return a;
    endfunction

    function longint weight(int k);
      longint c[5] = '{26713, 11763, 2281, 195, 7};
      int d, m;
      d = k - int'(Taps / 2);
      m = (d >= 0) ? d : -1 - d;
      return (m < 5) ? c[m] : 0;
    endfunction

    // Note an accepted input transfer and queue the bit it produces, if any.
    function void note_sample(logic signed [Sw-1:0] si, logic signed [Sw-1:0] sq,
                              bit restart);
      longint re, im, acc;
      int unsigned idx;
      bit sgn;
      if (restart) begin
        clear();
        return;
      end
      re = longint'(si) * last_i + longint'(sq) * last_q;
      im = longint'(sq) * last_i - longint'(si) * last_q;
      last_i = si;
      last_q = sq;
      angles[wr_idx] = disc(re, im);
      acc = 0;
      idx = wr_idx;
      for (int k = 0; k < Taps; k++) begin
        acc += weight(k) * longint'($signed(angles[idx]));
        idx = (idx == 0) ? Taps - 1 : idx - 1;
      end
      wr_idx = (wr_idx + 1 == Taps) ? 0 : wr_idx + 1;
      sgn = acc > 0;
      if (sgn != last_sign) begin
        if (phase < 32'h8000) phase += increment / 16;
        else phase -= increment / 16;
      end
      last_sign = sgn;
      phase += increment;
      if (phase > 32'hFFFF) begin
        bits_owed.insert(bits_owed.size(), sgn == last_slice);
        last_slice = sgn;
        phase &= 32'hFFFF;
      end
    endfunction

    task report_error(string msg);
      errors++;
      $display("[%0t] mismatch: %s", $realtime, msg);
    endtask

    // Compare one output transfer with the oldest owed bit.
    task check_bit(logic [7:0] data);
      bit want;
      if (bits_owed.size() == 0) begin
        report_error($sformatf("unexpected output transfer, tdata %h", data));
        return;
      end
      want = bits_owed.pop_front();
      if (data[0] !== want || data[7:1] !== '0)
        report_error($sformatf("data_bit %b, expected %b (tdata %h)",
                               data[0], want, data));
    endtask
  endclass

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 s_axis_tvalid = 1'b0;
  logic                 s_axis_tready;
  logic [2*Sw-1:0]      s_axis_tdata = '0;
  logic                 s_axis_tuser = 1'b0;
  logic                 m_axis_tvalid;
  logic                 m_axis_tready = 1'b0;
  logic [7:0]           m_axis_tdata;
  logic                 cfg_we = 1'b0;
  logic [IncW-1:0]      cfg_wdata = '0;

  bit_recovery_sb sb = new();
  bit stall_enable = 1'b1;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  gmsk_fm_bit_recovery_unit uut (
    .clk(clk), .rst_n(rst_n),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata),
    .cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
  );

  // Output side: every result transfer is checked at the rising edge.
  always @(posedge clk) begin
    if (rst_n && m_axis_tvalid && m_axis_tready) sb.check_bit(m_axis_tdata);
  end

  // The receiver stalls on its own pattern: phases of always-ready
  // alternate with phases of light or heavy random back-pressure.
  initial begin
    int mode;
    forever begin
      mode = $urandom_range(0, 2);
      repeat ($urandom_range(20, 300)) begin
        @(negedge clk);
        if (!stall_enable || mode == 0) m_axis_tready <= 1'b1;
        else if (mode == 1) m_axis_tready <= ($urandom_range(0, 3) != 0);
        else m_axis_tready <= ($urandom_range(0, 4) == 0);
      end
    end
  end

  int burst_left = 0;

  // Hand one sample to the unit. Gaps fall between bursts; the valid line
  // stays high across back-to-back transfers so it never toggles in a step.
  task automatic send_sample(logic [Sw-1:0] si, logic [Sw-1:0] sq, bit restart);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      if ($urandom_range(0, 2) != 0) begin
        s_axis_tvalid <= 1'b0;
        repeat ($urandom_range(1, 60)) @(negedge clk);
      end
    end
    burst_left--;
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {sq, si};
    s_axis_tuser  <= restart;
    do @(posedge clk); while (!s_axis_tready);
    sb.note_sample(si, sq, restart);
    @(negedge clk);
  endtask

  // Let the unit drain, then wait its latency so no silent sample is in flight.
  task automatic go_idle();
    s_axis_tvalid <= 1'b0;
    burst_left = 0;
    while (sb.bits_owed.size() != 0) @(negedge clk);
    repeat (DrainCycles) @(negedge clk);
  endtask

  task automatic write_increment(logic [IncW-1:0] v);
    go_idle();
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(negedge clk);
    cfg_we    <= 1'b0;
    sb.increment = v;
  endtask

  // A well-formed GMSK-like burst: a rotating phasor whose rotation flips
  // with random data, at random amplitude, with a little noise.
  task automatic send_gmsk(int n, int sps);
    real ph, amp, dph;
    bit b;
    ph  = $urandom_range(0, 6283) / 1000.0;
    amp = $urandom_range(100, 32000);
    b = 0;
    for (int k = 0; k < n; k++) begin
      if (k % sps == 0) b = $urandom_range(0, 1);
      dph = (b ? 1.0 : -1.0) * 3.14159 / (2.0 * sps);
      ph += dph;
      send_sample(Sw'($rtoi(amp * $cos(ph)) + $urandom_range(0, 6) - 3),
                  Sw'($rtoi(amp * $sin(ph)) + $urandom_range(0, 6) - 3), 1'b0);
    end
  endtask

  task automatic send_noise(int n);
    repeat (n) send_sample(Sw'($urandom), Sw'($urandom), ($urandom_range(0, 40) == 0));
  endtask

  initial begin
    logic [Sw-1:0]   ext[4];
    logic [IncW-1:0] incs[8];
    ext  = '{16'h8000, 16'h7FFF, 16'h0000, 16'hFFFF};
    incs = '{16'd13107, 16'd32768, 16'd1, 16'd0, 16'hFFFF,
             16'd16384, 16'd9000, 16'd13107};
    sb.increment = IncReset;
    sb.clear();
    repeat (7) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed: zero vectors, field extremes, a restart mid-stream.
    send_sample('0, '0, 1'b0);
    foreach (ext[a]) foreach (ext[b]) send_sample(ext[a], ext[b], 1'b0);
    send_sample(16'h1234, 16'h8765, 1'b1);
    send_sample(16'h7FFF, 16'h0000, 1'b0);
    send_sample(16'h0000, 16'h7FFF, 1'b0);
    send_sample(16'h8000, 16'h0000, 1'b0);

    // Pause until every owed bit has come out.
    go_idle();

    // Random phases over a range of increments, the extremes included.
    foreach (incs[p]) begin
      write_increment(incs[p]);
      if (p == 3) stall_enable = 1'b0;
      else stall_enable = 1'b1;
      repeat (4) begin
        send_gmsk($urandom_range(20, 40), 5);
        if ($urandom_range(0, 3) == 0) send_noise($urandom_range(1, 5));
      end
    end
    stall_enable = 1'b1;
    go_idle();
    if (sb.errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  // Watchdog for a run of roughly 1000 samples.
  initial begin
    #5ms;
    $display("FAILURE");
    $finish;
  end

endmodule
